[rtl/jac_pkg.sv]
package jac_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int SAMPLE_BITS  = 12;
    localparam int SLOT_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_BITS    = SLOT_BITS + 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [2:0] REG_FULL_SCALE = 3'd0;
    localparam logic [2:0] REG_JOY_DZ     = 3'd1;
    localparam logic [2:0] REG_TURN_DZ    = 3'd2;
    localparam logic [2:0] REG_SPEED_LO   = 3'd3;
    localparam logic [2:0] REG_SPEED_HI   = 3'd4;
    localparam logic [2:0] REG_INVERT     = 3'd5;

    localparam logic [11:0] FALLBACK_FULL_SCALE = 12'd4095;

    typedef struct packed {
        logic [11:0] sample_x;
        logic [11:0] sample_y;
        logic [11:0] sample_turn;
        logic [11:0] sample_speed;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_turn;
        logic [15:0]        speed_limit;
    } t_out_word;

    // divider request / response
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

[rtl/joystick_axis_conditioner.sv]
// channel | valid   | stall   | payload
// in      | i_valid | o_stall | i_word (jac_pkg::t_in_word)
// out     | o_valid | i_stall | o_word (jac_pkg::t_out_word)
// cfg     | i_cfg_we| -       | i_cfg_index, i_cfg_data
// One word at a time: each channel's sample is read from and written back to
// the sample memory, then up to eleven divisions run on the shared restoring
// divider, fewer when axes fall inside the deadzone. The divider loop sets the
// rate, and a finished word still waiting for the receiver can hold it too.
// Reset is synchronous, active low; the sample memory needs no clearing since
// a slot is only read once written. A finished word waits in the output
// register; a new word is taken while it waits, and its result holds until
// the old one is taken.
module joystick_axis_conditioner (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  jac_pkg::t_in_word    i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output jac_pkg::t_out_word   o_word,
    input  logic                 i_cfg_we,
    input  logic [jac_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [jac_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import jac_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_UPD = 4'd2,
                           S_AVG = 4'd3, S_AVGW = 4'd4, S_CEN = 4'd5,
                           S_CENW = 4'd6, S_DZ = 4'd7, S_DZW = 4'd8,
                           S_SPD = 4'd9, S_SPDW = 4'd10, S_FIN = 4'd11,
                           S_OUT = 4'd12;

    // configuration
    logic [11:0] r_fs; logic [14:0] r_jdz, r_tdz;
    logic [15:0] r_slo, r_shi; logic [2:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= 12'd4095; r_jdz <= '0; r_tdz <= '0;
            r_slo <= '0; r_shi <= 16'hFFFF; r_inv <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FULL_SCALE: r_fs  <= i_cfg_data[11:0];
                REG_JOY_DZ:     r_jdz <= i_cfg_data[14:0];
                REG_TURN_DZ:    r_tdz <= i_cfg_data[14:0];
                REG_SPEED_LO:   r_slo <= i_cfg_data;
                REG_SPEED_HI:   r_shi <= i_cfg_data;
                REG_INVERT:     r_inv <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic [3:0]  r_st, n_st;
    logic [1:0]  r_ch;
    logic [SLOT_BITS-1:0] r_slot;
    logic        r_full;
    t_in_word    r_in;
    logic [SUM_BITS-1:0] r_sum [0:3];
    logic [SAMPLE_BITS-1:0] r_avg [0:3];
    logic signed [16:0] r_v;
    logic        r_neg;
    logic [15:0] r_res [0:3];
    logic        r_ov;
    t_out_word   r_ow;

    logic [SAMPLE_BITS-1:0] smp, old;
    logic [ADDR_BITS-1:0] addr;
    t_div_req    dreq;
    t_div_rsp    drsp;

    always_comb begin
        unique case (r_ch)
            2'd0: smp = r_in.sample_x[SAMPLE_BITS-1:0];
            2'd1: smp = r_in.sample_y[SAMPLE_BITS-1:0];
            2'd2: smp = r_in.sample_turn[SAMPLE_BITS-1:0];
            default: smp = r_in.sample_speed[SAMPLE_BITS-1:0];
        endcase
    end

    assign addr = {r_ch, r_slot};

    jac_ram #(.AW(ADDR_BITS), .DW(SAMPLE_BITS)) u_ram (
        .i_clk(i_clk), .i_we(r_st == S_UPD), .i_waddr(addr), .i_wdata(smp),
        .i_raddr(addr), .o_rdata(old));

    jac_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    // derived values
    logic [11:0] full, half;
    logic [CNT_BITS-1:0] cnt;
    logic [15:0] hi;
    logic [14:0] dz;
    logic signed [13:0] diff;
    logic [12:0] mag;
    logic [16:0] vmag;
    logic [16:0] qc;
    logic signed [17:0] fin;
    assign full = (r_fs < 12'd2) ? FALLBACK_FULL_SCALE : r_fs;
    assign half = {1'b0, full[11:1]};
    assign cnt  = r_full ? CNT_BITS'(WINDOW_DEPTH) : CNT_BITS'({1'b0, r_slot} + 1);
    assign hi   = (r_shi < r_slo) ? r_slo : r_shi;
    assign dz   = (r_ch == 2'd2) ? r_tdz : r_jdz;
    assign diff = $signed({2'b0, r_avg[r_ch]}) - $signed({2'b0, half});
    assign mag  = diff[13] ? 13'(-diff) : 13'(diff);
    assign vmag = r_v[16] ? 17'(-r_v) : 17'(r_v);
    assign qc   = (drsp.quotient > 32'd32768) ? 17'd32768 : drsp.quotient[16:0];

    always_comb begin
        dreq = '0;
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid && !o_stall) n_st = S_RD;
            S_RD:    n_st = S_UPD;
            S_UPD:   n_st = (r_ch == 2'd3) ? S_AVG : S_RD;
            S_AVG: begin
                dreq.start = 1'b1;
                dreq.dividend = 32'(r_sum[r_ch]);
                dreq.divisor = 17'(cnt);
                n_st = S_AVGW;
            end
            S_AVGW:  if (drsp.done) n_st = (r_ch == 2'd3) ? S_CEN : S_AVG;
            S_CEN: begin
                if (r_ch == 2'd3) n_st = S_SPD;
                else begin
                    dreq.start = 1'b1;
                    dreq.dividend = {4'd0, mag, 15'd0};
                    dreq.divisor = {5'd0, half};
                    n_st = S_CENW;
                end
            end
            S_CENW:  if (drsp.done) n_st = S_DZ;
            S_DZ: begin
                if (vmag < {2'b0, dz}) n_st = S_FIN;
                else begin
                    dreq.start = 1'b1;
                    dreq.dividend = 32'(vmag - {2'b0, dz}) << 15;
                    dreq.divisor = 17'd32768 - {2'b0, dz};
                    n_st = S_DZW;
                end
            end
            S_DZW:   if (drsp.done) n_st = S_FIN;
            S_FIN:   n_st = S_CEN;
            S_SPD: begin
                dreq.start = 1'b1;
                dreq.dividend = 32'(r_avg[3]) * 32'(hi - r_slo);
                dreq.divisor = {5'd0, full};
                n_st = S_SPDW;
            end
            S_SPDW:  if (drsp.done) n_st = S_OUT;
            S_OUT:   if (!r_ov) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
    assign o_word  = r_ow;

    logic signed [17:0] vneg;
    logic [32:0] sp;
    assign vneg = r_neg ? -$signed({r_v[16], r_v}) : $signed({r_v[16], r_v});
    assign fin  = (vneg > 18'sd32767) ? 18'sd32767 :
                  (vneg < -18'sd32767) ? -18'sd32767 : vneg;
    assign sp   = {17'd0, r_slo} + {1'b0, drsp.quotient};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ch <= '0; r_slot <= '0; r_full <= 1'b0; r_ov <= 1'b0;
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_in <= i_word; r_ch <= 2'd0;
                end
                S_UPD: begin
                    // drop the slot's old sample once the window is full
                    r_sum[r_ch] <= r_sum[r_ch] - (r_full ? SUM_BITS'(old) : '0)
                                   + SUM_BITS'(smp);
                    r_ch <= r_ch + 2'd1;
                end
                S_AVGW: if (drsp.done) begin
                    r_avg[r_ch] <= SAMPLE_BITS'(drsp.quotient);
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd3) begin
                        r_slot <= (r_slot == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0
                                  : r_slot + 1'b1;
                        if (r_slot == SLOT_BITS'(WINDOW_DEPTH - 1)) r_full <= 1'b1;
                    end
                end
                S_CEN: begin
                    if (r_ch != 2'd3) r_neg <= r_inv[r_ch];
                end
                S_CENW: if (drsp.done)
                    r_v <= diff[13] ? -$signed(qc) : $signed(qc);
                S_DZ: if (vmag < {2'b0, dz}) r_v <= '0;
                S_DZW: if (drsp.done)
                    r_v <= r_v[16] ? -$signed(drsp.quotient[16:0])
                                   : $signed(drsp.quotient[16:0]);
                S_FIN: begin
                    r_res[r_ch] <= fin[15:0];
                    r_ch <= r_ch + 2'd1;
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_ow.axis_x <= r_res[0];
                    r_ow.axis_y <= r_res[1];
                    r_ow.axis_turn <= r_res[2];
                    r_ow.speed_limit <= r_res[3];
                end
                S_SPDW: if (drsp.done)
                    r_res[3] <= (sp > {17'd0, hi}) ? hi : sp[15:0];
                default: ;
            endcase
        end
    end
endmodule

[rtl/jac_ram.sv]
module jac_ram #(
    parameter int AW = 5,
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/jac_div.sv]
module jac_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jac_pkg::t_div_req     i_req,
    output jac_pkg::t_div_rsp     o_rsp
);
    import jac_pkg::*;

    logic [31:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [17:0] trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        trial = {r_rem, r_q[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_q = i_req.dividend; n_rem = '0; n_den = i_req.divisor;
            n_cnt = 6'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            // one quotient bit per cycle, restoring
            if (!trial[17]) begin
                n_rem = trial[16:0];
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_q[31]};
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

[tb/joystick_axis_checker.sv]
`timescale 1ns / 1ps

module joystick_axis_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  jac_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  jac_pkg::t_out_word i_out_word,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import jac_pkg::*;

    localparam int DEPTH = jac_pkg::WINDOW_DEPTH;

    logic [11:0] window_mem [4][DEPTH];
    longint      chan_sum [4];
    int          slot_ptr;
    bit          wrapped;

    logic [11:0] full_scale;
    logic [14:0] joy_dz, turn_dz;
    logic [15:0] spd_lo, spd_hi;
    logic [2:0]  inv_mask;

    t_out_word   expected_words [$];

    function automatic logic [15:0] condition_axis(longint avg, longint full, longint dz,
                                                   bit neg);
        longint half, diff, mag, q, v;
        half = full / 2;
        diff = avg - half;
        mag  = (diff < 0) ? -diff : diff;
        q    = (mag * 32768) / half;
        if (q > 32768) q = 32768;
        if (q < dz) q = 0;
        else q = ((q - dz) * 32768) / (32768 - dz);
        v = (diff < 0) ? -q : q;
        if (neg) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32767) v = -32767;
        return v[15:0];
    endfunction

    // advance the window by one word and return the conditioned outputs
    function automatic t_out_word condition_word(t_in_word w);
        t_out_word r;
        longint avg [4];
        longint smp [4];
        longint cnt, full, lo, hi, sp;
        smp[0] = w.sample_x;
        smp[1] = w.sample_y;
        smp[2] = w.sample_turn;
        smp[3] = w.sample_speed;
        cnt = wrapped ? DEPTH : slot_ptr + 1;
        for (int ch = 0; ch < 4; ch++) begin
            if (wrapped) chan_sum[ch] -= window_mem[ch][slot_ptr];
            window_mem[ch][slot_ptr] = smp[ch][11:0];
            chan_sum[ch] += smp[ch];
            avg[ch] = chan_sum[ch] / cnt;
        end
        slot_ptr = (slot_ptr + 1) % DEPTH;
        if (slot_ptr == 0) wrapped = 1;
        full = (full_scale < 2) ? FALLBACK_FULL_SCALE : full_scale;
        r.axis_x    = condition_axis(avg[0], full, joy_dz, inv_mask[0]);
        r.axis_y    = condition_axis(avg[1], full, joy_dz, inv_mask[1]);
        r.axis_turn = condition_axis(avg[2], full, turn_dz, inv_mask[2]);
        lo = spd_lo;
        hi = (spd_hi < spd_lo) ? spd_lo : spd_hi;
        sp = lo + (avg[3] * (hi - lo)) / full;
        if (sp > hi) sp = hi;
        r.speed_limit = sp[15:0];
        return r;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            for (int ch = 0; ch < 4; ch++) chan_sum[ch] = 0;
            slot_ptr   = 0;
            wrapped    = 0;
            full_scale = 12'd4095;
            joy_dz     = '0;
            turn_dz    = '0;
            spd_lo     = '0;
            spd_hi     = 16'hFFFF;
            inv_mask   = '0;
            o_fail_count = 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FULL_SCALE: full_scale = i_cfg_data[11:0];
                    REG_JOY_DZ:     joy_dz     = i_cfg_data[14:0];
                    REG_TURN_DZ:    turn_dz    = i_cfg_data[14:0];
                    REG_SPEED_LO:   spd_lo     = i_cfg_data;
                    REG_SPEED_HI:   spd_hi     = i_cfg_data;
                    REG_INVERT:     inv_mask   = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, i_out_word);
                    o_fail_count++;
                end else begin
                    e = expected_words.pop_front();
                    if (e.axis_x !== i_out_word.axis_x) begin
                        $display("%0t: axis_x expected %0d actual %0d", $time,
                                 e.axis_x, i_out_word.axis_x);
                        o_fail_count++;
                    end
                    if (e.axis_y !== i_out_word.axis_y) begin
                        $display("%0t: axis_y expected %0d actual %0d", $time,
                                 e.axis_y, i_out_word.axis_y);
                        o_fail_count++;
                    end
                    if (e.axis_turn !== i_out_word.axis_turn) begin
                        $display("%0t: axis_turn expected %0d actual %0d", $time,
                                 e.axis_turn, i_out_word.axis_turn);
                        o_fail_count++;
                    end
                    if (e.speed_limit !== i_out_word.speed_limit) begin
                        $display("%0t: speed_limit expected %0d actual %0d", $time,
                                 e.speed_limit, i_out_word.speed_limit);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_in_stall) expected_words.push_back(condition_word(i_in_word));
        end
    end

endmodule

[tb/tb_joystick_axis_conditioner.sv]
`timescale 1ns / 1ps

module tb_joystick_axis_conditioner;
    import jac_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_in_word    i_word = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_out_word   o_word;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    int  fail_count, pending;
    bit  quiet = 0;     // no idling on either side in the closing stretch
    int  stall_left = 0;
    int  calm_left = 0;

    always #5 i_clk = ~i_clk;

    joystick_axis_conditioner dut (.*);

    joystick_axis_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in_stall  (o_stall),
        .i_in_word   (i_word),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_word  (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // receiver back-pressure: bursts of stall, separated by calm stretches
    always @(posedge i_clk) begin
        if (quiet) begin
            i_stall <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1;
        end else if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            i_stall   <= 0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_stall    <= 1;
        end else begin
            calm_left <= $urandom_range(0, 60);
            i_stall   <= 0;
        end
    end

    // called at a rising edge; returns at the edge that accepts the word, or after a random idle gap that follows it
    task automatic send_word(t_in_word w);
        i_valid <= 1;
        i_word  <= w;
        forever begin
            @(negedge i_clk);
            if (!o_stall) break;
        end
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we    <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_regs(logic [11:0] fs, logic [14:0] jdz, logic [14:0] tdz,
                             logic [15:0] lo, logic [15:0] hi, logic [2:0] inv);
        write_reg(REG_FULL_SCALE, {4'd0, fs});
        write_reg(REG_JOY_DZ, {1'b0, jdz});
        write_reg(REG_TURN_DZ, {1'b0, tdz});
        write_reg(REG_SPEED_LO, lo);
        write_reg(REG_SPEED_HI, hi);
        write_reg(REG_INVERT, {13'd0, inv});
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // bias toward the rails and the centre, where the arithmetic turns
    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'($urandom_range(2040, 2056));
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w.sample_x     = pick_sample();
        w.sample_y     = pick_sample();
        w.sample_turn  = pick_sample();
        w.sample_speed = pick_sample();
        return w;
    endfunction

    function automatic logic [14:0] pick_deadzone();
        case ($urandom_range(0, 3))
            0: return 15'd0;
            1: return 15'd32767;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_full_scale();
        case ($urandom_range(0, 6))
            0: return 12'd4095;
            1: return 12'd2;
            2: return 12'($urandom_range(0, 1));
            3: return 12'($urandom_range(2, 300));
            default: return 12'($urandom_range(2, 4095));
        endcase
    endfunction

    initial begin
        t_in_word w;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // partial window at reset values, then rails and centre
        send_word(t_in_word'{12'd0, 12'd4095, 12'd2047, 12'd0});
        send_word(t_in_word'{12'd4095, 12'd0, 12'd2048, 12'd4095});
        send_word(t_in_word'{12'd2047, 12'd2048, 12'd4095, 12'd2047});
        for (int i = 0; i < 6; i++)
            send_word(t_in_word'{12'd4095, 12'd0, 12'd0, 12'd4095});
        settle();

        // small full scale: averages above it clamp; floor above ceiling
        load_regs(12'd2, 15'd32767, 15'd16384, 16'd50000, 16'd100, 3'b111);
        for (int i = 0; i < 4; i++)
            send_word(t_in_word'{12'd4095, 12'd1, 12'd0, 12'd4095});
        settle();
        // full scale below two falls back to the default
        load_regs(12'd1, 15'd0, 15'd32767, 16'd0, 16'd65535, 3'b010);
        for (int i = 0; i < 4; i++)
            send_word(t_in_word'{12'd0, 12'd4095, 12'd3000, 12'd1000});
        settle();
        load_regs(12'd0, 15'd1000, 15'd1, 16'd65535, 16'd65535, 3'b101);
        for (int i = 0; i < 4; i++)
            send_word(t_in_word'{12'd1024, 12'd3072, 12'd4095, 12'd4095});
        settle();

        // random phases, each under its own register set
        for (int p = 0; p < 16; p++) begin
            load_regs(pick_full_scale(), pick_deadzone(), pick_deadzone(),
                      16'($urandom), ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                      3'($urandom));
            if (p == 15) quiet = 1;
            for (int i = 0; i < 105; i++) begin
                w = random_word();
                send_word(w);
            end
            settle();
        end

        repeat (500) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("status: fail");
        $finish;
    end

endmodule
